>>> hdl/bfth_pkg.sv
// ----------------------------------------------------------------------------
// Bound-field tuple hash: shared types and constants
// Hash mode codes, register index, FSM state type, hash constants and the
// control/status bundles that run between the top level and the byte core.
// ----------------------------------------------------------------------------
package bfth_pkg;

  typedef enum logic [1:0] {
    MODE_FNV1A  = 2'd0,
    MODE_DJB2   = 2'd1,
    MODE_RS     = 2'd2,
    MODE_MURMUR = 2'd3
  } hash_mode_e;

  // Register index as decoded from paddr[2]
  localparam logic REG_IDX_HASH_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BYTES,
    ST_FIN_WAIT,
    ST_FIN_MUL,
    ST_FIN_OUT
  } bfth_state_e;

  // Murmur3 round and finalizer constants
  localparam logic [31:0] MUR_C1   = 32'hcc9e2d51;
  localparam logic [31:0] MUR_C2   = 32'h1b873593;
  localparam logic [31:0] MUR_ADD  = 32'he6546b64;
  localparam logic [31:0] MUR_F1   = 32'h85ebca6b;
  localparam logic [31:0] MUR_F2   = 32'hc2b2ae35;
  localparam logic [31:0] MUR_SEED = 32'h84222325;

  // Low 32 bits of the 64-bit FNV prime and offset basis
  localparam logic [31:0] FNV_PRIME_LO = 32'h000001b3;
  localparam logic [31:0] FNV_BASIS_LO = 32'h84222325;

  localparam logic [31:0] DJB_SEED = 32'd5381;
  localparam logic [31:0] RS_B     = 32'd378551;
  localparam logic [31:0] RS_A0    = 32'd63689;

  localparam int unsigned BYTE_CNT_W = 12;

  typedef struct packed {
    logic byte_vld;  // one byte beat into the core this cycle
    logic clear;     // reload seeds for a fresh tuple
  } core_ctrl_t;

  typedef struct packed {
    logic                  busy;        // murmur pipeline still holds bytes
    logic [BYTE_CNT_W-1:0] byte_count;  // bound bytes taken, mod 4096
  } core_stat_t;

  function automatic logic [31:0] mode_seed(hash_mode_e mode);
    logic [31:0] seed;
    unique case (mode)
      MODE_FNV1A: seed = FNV_BASIS_LO;
      MODE_DJB2:  seed = DJB_SEED;
      MODE_RS:    seed = 32'd0;
      default:    seed = 32'd0;
    endcase
    return seed;
  endfunction

endpackage

>>> hdl/bfth_byte_core.sv
// ----------------------------------------------------------------------------
// Bound-field tuple hash: byte core
// Takes one byte per cycle and updates the primary hash accumulator and a
// three-stage Murmur3 round pipeline.
// ----------------------------------------------------------------------------
module bfth_byte_core
  import bfth_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hash_mode_e  mode_i,
  input  core_ctrl_t  ctrl_i,
  input  logic [7:0]  byte_i,
  output logic [31:0] main_acc_o,
  output logic [31:0] murmur_acc_o,
  output core_stat_t  stat_o
);

  logic [31:0]           main_acc_q, main_acc_d;
  logic [31:0]           rs_mult_q, rs_mult_d;
  logic [31:0]           mur_q, mur_d;
  logic [BYTE_CNT_W-1:0] cnt_q, cnt_d;
  logic                  v1_q, v2_q;
  logic [31:0]           k1_q, k2_q;
  logic [31:0]           k1_rot, mur_mix, byte_ext;

  assign byte_ext = {24'd0, byte_i};
  assign k1_rot   = {k1_q[16:0], k1_q[31:17]};
  assign mur_mix  = {mur_q[18:0] ^ k2_q[18:0], mur_q[31:19] ^ k2_q[31:19]};

  always_comb begin
    main_acc_d = main_acc_q;
    rs_mult_d  = rs_mult_q;
    mur_d      = mur_q;
    cnt_d      = cnt_q;
    if (ctrl_i.clear) begin
      main_acc_d = mode_seed(mode_i);
      rs_mult_d  = RS_A0;
      mur_d      = MUR_SEED;
      cnt_d      = '0;
    end else begin
      if (ctrl_i.byte_vld) begin
        unique case (mode_i)
          MODE_FNV1A: main_acc_d = (main_acc_q ^ byte_ext) * FNV_PRIME_LO;
          MODE_DJB2:  main_acc_d = (main_acc_q << 5) + main_acc_q + byte_ext;
          MODE_RS: begin
            main_acc_d = main_acc_q * rs_mult_q + byte_ext;
            rs_mult_d  = rs_mult_q * RS_B;
          end
          default:    main_acc_d = main_acc_q;
        endcase
        cnt_d = cnt_q + 1'b1;
      end
      // Final round stage: xor, rotate by 13, times five plus constant
      if (v2_q) begin
        mur_d = (mur_mix << 2) + mur_mix + MUR_ADD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_acc_q <= FNV_BASIS_LO;
      rs_mult_q  <= RS_A0;
      mur_q      <= MUR_SEED;
      cnt_q      <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
    end else begin
      main_acc_q <= main_acc_d;
      rs_mult_q  <= rs_mult_d;
      mur_q      <= mur_d;
      cnt_q      <= cnt_d;
      v1_q       <= ctrl_i.byte_vld & ~ctrl_i.clear;
      v2_q       <= v1_q & ~ctrl_i.clear;
    end
  end

  // Round pipeline payload: k = rotl(b * C1, 15) * C2
  always_ff @(posedge clk_i) begin
    k1_q <= byte_ext * MUR_C1;
    k2_q <= k1_rot * MUR_C2;
  end

  assign main_acc_o        = main_acc_q;
  assign murmur_acc_o      = mur_q;
  assign stat_o.busy       = v1_q | v2_q;
  assign stat_o.byte_count = cnt_q;

endmodule

>>> hdl/bound_field_tuple_hash_unit.sv
// ----------------------------------------------------------------------------
// Bound-field tuple hash unit
// Hashes a tuple of 64-bit cells; bound cells feed their bytes, LSB first,
// into a selectable primary hash and a Murmur3 side hash.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-------------------------------
//  cell in  | input     | in_valid_i/in_ready_o| cell_value_i, is_bound_i,
//           |           |                      | last_cell_i
//  result   | output    | out_valid_o/         | primary_hash_o, probe_step_o
//           |           | out_ready_i          |
//  config   | input     | APB psel/penable     | hash_mode at address 0
//
//  A bound cell feeds one byte per cycle; the next cell is taken on its last
//  byte unless it was a last cell, and an unbound cell feeds no bytes.
//  A last cell then waits for the Murmur pipeline to drain, then runs the two
//  finalizer multiplies (ST_FIN_WAIT, ST_FIN_MUL) and the output load.
//  A waiting result stalls the next tuple's finish, which holds off cells too.
//  Reset loads the seeds for mode 0 (FNV-1a); no clearing pass is needed.
//
module bound_field_tuple_hash_unit
  import bfth_pkg::*;
#(
  parameter int unsigned MAX_CELLS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cell input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] cell_value_i,
  input  logic        is_bound_i,
  input  logic        last_cell_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] primary_hash_o,
  output logic [31:0] probe_step_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CNT_W = $clog2(MAX_CELLS + 1);

  bfth_state_e state_q, state_d;

  hash_mode_e  hash_mode_q, hash_mode_d;
  logic [63:0] shift_q;
  logic [2:0]  byte_idx_q;
  logic        last_q;
  logic [CNT_W-1:0] cell_cnt_q;
  logic        first_seen_q;
  logic [31:0] first_word_q;
  logic [31:0] fin_q, fin_d;
  logic        out_vld_q;
  logic [31:0] prim_q, probe_q;

  logic        cfg_wr, in_acc, cell_room, take, out_free, fin_load, tuple_clr;
  logic        last_byte;
  logic [31:0] main_acc, mur_acc, mur_x, mur_h, fin_h2, mur_fin;
  core_ctrl_t  core_ctrl;
  core_stat_t  core_stat;

  // --------------------------------------------------------------------------
  // Configuration port: always ready, one register at index 0
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_IDX_HASH_MODE);
  assign prdata = (paddr[2] == REG_IDX_HASH_MODE) ? {30'd0, hash_mode_q} : 32'd0;
  assign hash_mode_d = cfg_wr ? hash_mode_e'(pwdata[1:0]) : hash_mode_q;

  // --------------------------------------------------------------------------
  // Input acceptance
  // --------------------------------------------------------------------------
  assign last_byte = (state_q == ST_BYTES) && (byte_idx_q == 3'd7);
  assign in_acc    = in_valid_i & in_ready_o;
  assign cell_room = (cell_cnt_q < CNT_W'(MAX_CELLS));
  assign take      = in_acc & is_bound_i & cell_room;
  assign out_free  = ~out_vld_q | out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (take)             state_d = ST_BYTES;
          else if (last_cell_i) state_d = ST_FIN_WAIT;
        end
      end
      ST_BYTES: begin
        if (byte_idx_q == 3'd7) begin
          if (in_acc) begin
            if (take)             state_d = ST_BYTES;
            else if (last_cell_i) state_d = ST_FIN_WAIT;
            else                  state_d = ST_IDLE;
          end else begin
            state_d = last_q ? ST_FIN_WAIT : ST_IDLE;
          end
        end
      end
      ST_FIN_WAIT: if (!core_stat.busy) state_d = ST_FIN_MUL;
      ST_FIN_MUL:  state_d = ST_FIN_OUT;
      ST_FIN_OUT:  if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o         = 1'b0;
    core_ctrl.byte_vld = 1'b0;
    fin_load           = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_BYTES: begin
        core_ctrl.byte_vld = 1'b1;
        in_ready_o         = last_byte & ~last_q;
      end
      ST_FIN_OUT: fin_load = out_free;
      default: ;
    endcase
  end

  // Drop tuple state after a result and on any mode write
  assign tuple_clr       = fin_load | cfg_wr;
  assign core_ctrl.clear = tuple_clr;

  // --------------------------------------------------------------------------
  // Byte core
  // --------------------------------------------------------------------------
  bfth_byte_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (hash_mode_d),
    .ctrl_i       (core_ctrl),
    .byte_i       (shift_q[7:0]),
    .main_acc_o   (main_acc),
    .murmur_acc_o (mur_acc),
    .stat_o       (core_stat)
  );

  // --------------------------------------------------------------------------
  // Finalizer: length xor, then fmix32 (multiplies in ST_FIN_WAIT, ST_FIN_MUL)
  // --------------------------------------------------------------------------
  assign mur_x   = mur_acc ^ {20'd0, core_stat.byte_count};
  assign mur_h   = mur_x ^ (mur_x >> 16);
  assign fin_h2  = fin_q ^ (fin_q >> 13);
  assign mur_fin = fin_q ^ (fin_q >> 16);

  always_comb begin
    fin_d = fin_q;
    unique case (state_q)
      ST_FIN_WAIT: fin_d = mur_h * MUR_F1;
      ST_FIN_MUL:  fin_d = fin_h2 * MUR_F2;
      default:     fin_d = fin_q;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hash_mode_q  <= MODE_FNV1A;
      byte_idx_q   <= '0;
      last_q       <= 1'b0;
      cell_cnt_q   <= '0;
      first_seen_q <= 1'b0;
      first_word_q <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      hash_mode_q <= hash_mode_d;

      if (in_acc) begin
        byte_idx_q <= '0;
        last_q     <= last_cell_i;
      end else if (state_q == ST_BYTES) begin
        byte_idx_q <= byte_idx_q + 3'd1;
      end

      if (tuple_clr) begin
        cell_cnt_q   <= '0;
        first_seen_q <= 1'b0;
        first_word_q <= '0;
      end else begin
        if (in_acc && cell_room) cell_cnt_q <= cell_cnt_q + 1'b1;
        if (take && !first_seen_q) begin
          first_seen_q <= 1'b1;
          first_word_q <= cell_value_i[31:0];
        end
      end

      // Hold the result until its beat is taken
      if (fin_load)         out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    fin_q <= fin_d;
    // Load the cell, or advance one byte toward the LSB
    if (take) shift_q <= cell_value_i;
    else      shift_q <= {8'd0, shift_q[63:8]};
    if (fin_load) begin
      prim_q  <= (hash_mode_q == MODE_MURMUR) ? mur_fin : main_acc;
      probe_q <= mur_fin + first_word_q;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign primary_hash_o = prim_q;
  assign probe_step_o   = probe_q;

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bound-field tuple hash unit testbench
// Streams tuples of 64-bit cells into the unit, predicts the primary hash and
// probe step of every finished tuple in all four hash modes, and checks each
// result beat in order under idling, back-pressure and mode changes.
// ----------------------------------------------------------------------------
module testbench
  import bfth_pkg::*;
();

  localparam int unsigned CELL_LIMIT   = 256;
  localparam int unsigned DRAIN_CYCLES = 40;   // longest cell plus finish, with margin
  localparam int unsigned PHASE_ITEMS  = 130;
  localparam int unsigned HOLD_CYCLES  = 600;

  // Register map: hash mode at word 0, word 1 unmapped
  localparam int unsigned REG_HASH_MODE  = 0;
  localparam logic [2:0]  ADDR_HASH_MODE = 3'd0;
  localparam logic [2:0]  ADDR_UNMAPPED  = 3'd4;

  // Hash constants, kept local so the prediction stands on its own
  localparam logic [31:0] K_C1        = 32'hcc9e2d51;
  localparam logic [31:0] K_C2        = 32'h1b873593;
  localparam logic [31:0] K_MUR_ADD   = 32'he6546b64;
  localparam logic [31:0] K_F1        = 32'h85ebca6b;
  localparam logic [31:0] K_F2        = 32'hc2b2ae35;
  localparam logic [31:0] K_MUR_SEED  = 32'h84222325;
  localparam logic [31:0] K_FNV_PRIME = 32'h000001b3;
  localparam logic [31:0] K_FNV_BASIS = 32'h84222325;
  localparam logic [31:0] K_DJB_SEED  = 32'd5381;
  localparam logic [31:0] K_RS_B      = 32'd378551;
  localparam logic [31:0] K_RS_A0     = 32'd63689;

  typedef struct packed {
    logic [63:0] value;
    logic        bound;
    logic        last;
  } cell_beat_t;

  typedef struct packed {
    logic [31:0] primary;
    logic [31:0] probe;
  } tuple_hash_t;

  // Clock, reset and DUT ports; every input starts at a known value
  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [63:0] cell_value_i = '0;
  logic        is_bound_i   = 1'b0;
  logic        last_cell_i  = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic [31:0] primary_hash_o;
  logic [31:0] probe_step_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  // Stimulus and checking state
  cell_beat_t  cell_queue[$];       // cells waiting to be offered
  tuple_hash_t pending_hashes[$];   // predicted results, oldest first
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  logic        hold_rx      = 1'b0;
  int          phase_idx    = -1;
  int unsigned mismatch_count = 0;

  // Predicted hash state of the tuple in progress
  hash_mode_e  cur_mode;
  logic [31:0] main_acc_q;
  logic [31:0] rs_mul_q;
  logic [31:0] mur_acc_q;
  logic [31:0] first_low_q;
  logic [11:0] bound_bytes_q;
  logic        first_seen_q;
  int unsigned cells_seen_q;

  bound_field_tuple_hash_unit #(
    .MAX_CELLS(CELL_LIMIT)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cell_value_i  (cell_value_i),
    .is_bound_i    (is_bound_i),
    .last_cell_i   (last_cell_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .primary_hash_o(primary_hash_o),
    .probe_step_o  (probe_step_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Hash prediction
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Murmur finalizer: fold and multiply until every bit has spread
  function automatic logic [31:0] fmix(input logic [31:0] h);
    logic [31:0] v;
    v = h ^ (h >> 16);
    v = v * K_F1;
    v = v ^ (v >> 13);
    v = v * K_F2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  // Reload the seeds of the current mode and forget the tuple in progress
  task automatic restart_tuple();
    case (cur_mode)
      MODE_FNV1A: main_acc_q = K_FNV_BASIS;
      MODE_DJB2:  main_acc_q = K_DJB_SEED;
      default:    main_acc_q = '0;
    endcase
    rs_mul_q      = K_RS_A0;
    mur_acc_q     = K_MUR_SEED;
    bound_bytes_q = '0;
    first_seen_q  = 1'b0;
    first_low_q   = '0;
    cells_seen_q  = 0;
  endtask

  // Advance both hashes by one byte
  task automatic absorb_byte(input logic [7:0] b);
    logic [31:0] k;
    logic [31:0] bw;
    bw = {24'd0, b};
    k = bw * K_C1;
    k = rotl(k, 15);
    k = k * K_C2;
    mur_acc_q = rotl(mur_acc_q ^ k, 13) * 32'd5 + K_MUR_ADD;
    case (cur_mode)
      MODE_FNV1A: main_acc_q = (main_acc_q ^ bw) * K_FNV_PRIME;
      MODE_DJB2:  main_acc_q = main_acc_q * 32'd33 + bw;
      MODE_RS: begin
        main_acc_q = main_acc_q * rs_mul_q + bw;
        rs_mul_q   = rs_mul_q * K_RS_B;
      end
      default: ;
    endcase
    bound_bytes_q = bound_bytes_q + 12'd1;
  endtask

  // Take one accepted cell; on the last cell queue the expected result
  task automatic advance_tuple_hash(input logic [63:0] cell_word, input logic bound,
                                    input logic last);
    tuple_hash_t res;
    logic [31:0] mur;
    int          i;
    // cells past the limit are dropped, but their last mark still counts
    if (cells_seen_q < CELL_LIMIT) begin
      cells_seen_q++;
      if (bound) begin
        if (!first_seen_q) begin
          first_seen_q = 1'b1;
          first_low_q  = cell_word[31:0];
        end
        for (i = 0; i < 8; i++) absorb_byte(cell_word[8*i +: 8]);
      end
    end
    if (last) begin
      mur = fmix(mur_acc_q ^ {20'd0, bound_bytes_q});
      res.primary = (cur_mode == MODE_MURMUR) ? mur : main_acc_q;
      res.probe   = mur + first_low_q;
      pending_hashes.push_back(res);
      restart_tuple();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Cell driver: predict on every accepted beat, then offer the next cell
  // unless this cycle rolls an idle. Valid and payload hold while stalled.
  always @(posedge clk_i) begin : cell_driver
    cell_beat_t beat;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_tuple_hash(cell_value_i, is_bound_i, last_cell_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (cell_queue.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
          beat = cell_queue.pop_front();
          in_valid_i   <= 1'b1;
          cell_value_i <= beat.value;
          is_bound_i   <= beat.bound;
          last_cell_i  <= beat.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each result beat against the oldest prediction,
  // then pick ready for the next cycle (dropped during the long hold-off)
  always @(posedge clk_i) begin : result_monitor
    tuple_hash_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_hashes.size() == 0) begin
          flag_mismatch($sformatf("result beat %h/%h with no finished tuple",
                                  primary_hash_o, probe_step_o));
        end else begin
          want = pending_hashes.pop_front();
          if (primary_hash_o !== want.primary) begin
            flag_mismatch($sformatf("primary_hash %h, predicted %h (mode %s)",
                                    primary_hash_o, want.primary, cur_mode.name()));
          end
          if (probe_step_o !== want.probe) begin
            flag_mismatch($sformatf("probe_step %h, predicted %h (mode %s)",
                                    probe_step_o, want.probe, cur_mode.name()));
          end
        end
      end
      out_ready_i <= !hold_rx && ($urandom_range(99, 0) >= rx_stall_pct);
    end
  end

  // Long receiver hold-off while the sender keeps streaming: the output
  // register fills, the next finish stalls and in_ready_o must drop
  initial begin : rx_holdoff
    wait (phase_idx == 4);
    repeat (20) @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [63:0] pick_cell();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      2:       return {32'd0, $urandom};
      3:       return {$urandom, 32'd0};
      4:       return 64'd1 << $urandom_range(63, 0);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic push_cell(input logic [63:0] value, input logic bound, input logic last);
    cell_beat_t beat;
    beat.value = value;
    beat.bound = bound;
    beat.last  = last;
    cell_queue.push_back(beat);
  endtask

  task automatic queue_tuple(input int unsigned len, input int unsigned bound_pct);
    int unsigned n;
    for (n = 0; n < len; n++) begin
      push_cell(pick_cell(), $urandom_range(99, 0) < bound_pct, n == len - 1);
    end
  endtask

  // Mostly short tuples with random content, some longer ones, and a few
  // with no bound cell at all
  task automatic queue_random_tuples(input int unsigned items);
    int unsigned count;
    int unsigned roll;
    int unsigned len;
    count = 0;
    while (count < items) begin
      roll = $urandom_range(99, 0);
      if (roll < 10) begin
        len = $urandom_range(4, 1);
        queue_tuple(len, 0);
      end else if (roll < 85) begin
        len = $urandom_range(6, 1);
        queue_tuple(len, 75);
      end else begin
        len = $urandom_range(20, 7);
        queue_tuple(len, 60);
      end
      count += len;
    end
  endtask

  // Hold until every cell is in, every result is out, then let the core settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (cell_queue.size() != 0 || in_valid_i || pending_hashes.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access until pready; mirror it in the model
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    int unsigned reg_index;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_index = {31'd0, addr[2]};
    if (reg_index == REG_HASH_MODE) begin
      cur_mode = hash_mode_e'(data[1:0]);
      restart_tuple();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    hash_mode_e  mode_sel;
    int unsigned m;
    int unsigned p;
    cur_mode = MODE_FNV1A;
    restart_tuple();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset mode FNV-1a
    push_cell(64'hdead_beef_0000_0001, 1'b0, 1'b1);   // tuple with nothing bound
    push_cell('0, 1'b1, 1'b1);
    push_cell('1, 1'b1, 1'b1);
    push_cell(64'h0123_4567_89ab_cdef, 1'b0, 1'b0);   // first bound cell is the second
    push_cell(64'hfedc_ba98_7654_3210, 1'b1, 1'b0);
    push_cell('1, 1'b1, 1'b1);
    // an unmapped write in mid-tuple must leave the tuple alone
    push_cell(64'hdead_beef_cafe_f00d, 1'b1, 1'b0);
    wait_drained();
    apb_write(ADDR_UNMAPPED, {30'd0, MODE_MURMUR});
    push_cell(64'h8000_0000_0000_0001, 1'b1, 1'b1);
    // a mode write in mid-tuple drops the partial tuple
    push_cell(64'h1111_2222_3333_4444, 1'b1, 1'b0);
    wait_drained();
    apb_write(ADDR_HASH_MODE, {30'd0, MODE_DJB2});
    push_cell(64'h5555_5555_aaaa_aaaa, 1'b1, 1'b1);
    // same short set in every other mode; junk in the upper bits for RS
    for (m = 1; m < 4; m++) begin
      mode_sel = hash_mode_e'(m);
      wait_drained();
      if (mode_sel == MODE_RS) apb_write(ADDR_HASH_MODE, 32'ha5a5_a5a4 | {30'd0, mode_sel});
      else apb_write(ADDR_HASH_MODE, {30'd0, mode_sel});
      push_cell('0, 1'b0, 1'b1);
      push_cell('1, 1'b1, 1'b0);
      push_cell(64'h5555_5555_aaaa_aaaa, 1'b1, 1'b1);
    end

    // Random phases: cycle the idling patterns and the hash modes
    for (p = 0; p < 8; p++) begin
      wait_drained();
      mode_sel = hash_mode_e'((p + p / 4) % 4);
      apb_write(ADDR_HASH_MODE, {30'd0, mode_sel});
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 64;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 64;
        end
        default: begin
          tx_idle_pct  = 7;
          rx_stall_pct = 7;
        end
      endcase
      phase_idx = p;
      queue_random_tuples(PHASE_ITEMS);
      // a tuple exactly at the cell limit, and one that runs past it
      if (p == 5) queue_tuple(CELL_LIMIT, 50);
      if (p == 7) queue_tuple(CELL_LIMIT + $urandom_range(40, 1), 50);
    end
    wait_drained();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
